### src/spp_pkg.sv
// spp_pkg: shared constants, payload structs and the CORDIC angle table
// for the sprite screen projection pipeline. No dependencies.
`default_nettype none

package spp_pkg;

    localparam int SCREEN_WIDTH = 1024;
    localparam int FOV_DEG      = 60;

    // Pipeline cell counts
    localparam int CORDIC_STEPS = 18;
    localparam int SQRT_STEPS   = 33;
    localparam int CTR_STEPS    = 37;   // quotient bits of the column divide
    localparam int HALF_STEPS   = 47;   // scale*2^15 / distance
    localparam int SIZE_STEPS   = 32;   // scale / depth

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_ANGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 3'd4;

    localparam logic signed [37:0] CORDIC_GAIN  = 38'sd652032874;
    localparam logic signed [25:0] HALF_TURN    = 26'sd8388608;
    localparam logic signed [25:0] QUARTER_TURN = 26'sd4194304;
    localparam logic signed [25:0] FULL_TURN    = 26'sd16777216;

    // center = floor(SW*(720*z + FOV*2^24) / (FOV*512)); an offset of
    // CTR_OFS divisors keeps the dividend positive over the whole z range.
    localparam int     CTR_DIV = FOV_DEG * 512;
    localparam longint CTR_OFS = 64'sd1 <<< 36;
    localparam logic signed [55:0] CTR_MUL = 56'(SCREEN_WIDTH * 720);
    localparam logic signed [55:0] CTR_ADD =
        56'(longint'(SCREEN_WIDTH) * longint'(FOV_DEG) * 64'sd16777216
            + CTR_OFS * longint'(CTR_DIV));
    localparam logic signed [37:0] CTR_OFS_Q = 38'(CTR_OFS);

    // Side data that travels with a transaction down the whole chain
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [32:0]        distance;
        logic signed [35:0] rx;
        logic               projected;
        logic signed [37:0] center;
        logic [46:0]        half;
    } sb_t;

    typedef struct packed {
        logic [65:0] rad;
        logic [34:0] rem;
        logic [32:0] root;
    } sq_t;

    typedef struct packed {
        logic signed [37:0] x;
        logic signed [37:0] y;
        logic signed [25:0] z;
    } cd_t;

    typedef struct packed {
        logic [35:0] rem;
        logic [63:0] num;
        logic [63:0] quo;
        logic [35:0] dvs;
    } dv_t;

    // atan(2^-i) in units of 2^24 per turn
    function automatic logic signed [25:0] atan_unit(input logic [4:0] i);
        logic signed [25:0] a;
        case (i)
            5'd0:    a = 26'sd2097152;
            5'd1:    a = 26'sd1238021;
            5'd2:    a = 26'sd654136;
            5'd3:    a = 26'sd332050;
            5'd4:    a = 26'sd166669;
            5'd5:    a = 26'sd83416;
            5'd6:    a = 26'sd41718;
            5'd7:    a = 26'sd20860;
            5'd8:    a = 26'sd10430;
            5'd9:    a = 26'sd5215;
            5'd10:   a = 26'sd2608;
            5'd11:   a = 26'sd1304;
            5'd12:   a = 26'sd652;
            5'd13:   a = 26'sd326;
            5'd14:   a = 26'sd163;
            5'd15:   a = 26'sd81;
            5'd16:   a = 26'sd41;
            5'd17:   a = 26'sd20;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### src/spp_if.sv
// spp_if: valid/ready channel interfaces of the sprite projection block
// (sprite input, result output, configuration writes). No dependencies.
`default_nettype none

interface spp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sprite_x;
    logic signed [31:0] sprite_y;
    modport source (output valid, sprite_x, sprite_y, input ready);
    modport sink   (input valid, sprite_x, sprite_y, output ready);
endinterface

interface spp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] col_begin;
    logic signed [15:0] col_end;
    logic [31:0]        depth;
    logic [15:0]        sprite_size;
    logic               projected;
    modport source (output valid, col_begin, col_end, depth, sprite_size, projected,
                    input ready);
    modport sink   (input valid, col_begin, col_end, depth, sprite_size, projected,
                    output ready);
endinterface

interface spp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/spp_sqrt_cell.sv
// spp_sqrt_cell: one bit of the restoring square root, registered.
// Depends on spp_pkg (sq_t, sb_t).
`default_nettype none

module spp_sqrt_cell
    import spp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic vld_in,
    input  sq_t  sq_in,
    input  sb_t  sb_in,
    output logic vld_out,
    output sq_t  sq_out,
    output sb_t  sb_out
);

    logic        vld_reg;
    sq_t         sq_reg;
    sq_t         sq_next;
    sb_t         sb_reg;
    logic [36:0] rem2;
    logic [36:0] trial;
    logic [36:0] diff;
    logic        ge;

    always_comb
    begin
        rem2  = {sq_in.rem, sq_in.rad[65:64]};
        trial = {2'b00, sq_in.root, 2'b01};
        diff  = rem2 - trial;
        ge    = (rem2 >= trial);
        sq_next.rad  = {sq_in.rad[63:0], 2'b00};
        sq_next.rem  = ge ? diff[34:0] : rem2[34:0];
        sq_next.root = {sq_in.root[31:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
            sb_reg <= sb_in;
        end
    end

    assign vld_out = vld_reg;
    assign sq_out  = sq_reg;
    assign sb_out  = sb_reg;

endmodule

`default_nettype wire

### src/spp_cordic_cell.sv
// spp_cordic_cell: one registered CORDIC micro-rotation, rotation or
// vectoring mode. Depends on spp_pkg (cd_t, sb_t, atan_unit).
`default_nettype none

module spp_cordic_cell
    import spp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       mode,    // 1: vectoring, 0: rotation
    input  logic [4:0] step,
    input  logic       vld_in,
    input  cd_t        cd_in,
    input  sb_t        sb_in,
    output logic       vld_out,
    output cd_t        cd_out,
    output sb_t        sb_out
);

    logic               vld_reg;
    cd_t                cd_reg;
    cd_t                cd_next;
    sb_t                sb_reg;
    logic signed [37:0] xi;
    logic signed [37:0] yi;
    logic signed [25:0] zi;
    logic signed [37:0] xs;
    logic signed [37:0] ys;
    logic signed [25:0] a;
    logic               pos;

    always_comb
    begin
        xi  = cd_in.x;
        yi  = cd_in.y;
        zi  = cd_in.z;
        xs  = xi >>> step;
        ys  = yi >>> step;
        a   = atan_unit(step);
        pos = mode ? !(yi > 38'sd0) : (zi >= 26'sd0);
        if (pos)
        begin
            cd_next.x = xi - ys;
            cd_next.y = yi + xs;
            cd_next.z = zi - a;
        end
        else
        begin
            cd_next.x = xi + ys;
            cd_next.y = yi - xs;
            cd_next.z = zi + a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_reg <= cd_next;
            sb_reg <= sb_in;
        end
    end

    assign vld_out = vld_reg;
    assign cd_out  = cd_reg;
    assign sb_out  = sb_reg;

endmodule

`default_nettype wire

### src/spp_div_cell.sv
// spp_div_cell: one quotient bit of an unsigned restoring divide, registered.
// Depends on spp_pkg (dv_t, sb_t).
`default_nettype none

module spp_div_cell
    import spp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic vld_in,
    input  dv_t  dv_in,
    input  sb_t  sb_in,
    output logic vld_out,
    output dv_t  dv_out,
    output sb_t  sb_out
);

    logic        vld_reg;
    dv_t         dv_reg;
    dv_t         dv_next;
    sb_t         sb_reg;
    logic [36:0] rem2;
    logic [36:0] diff;
    logic        ge;

    always_comb
    begin
        rem2 = {dv_in.rem, dv_in.num[63]};
        diff = rem2 - {1'b0, dv_in.dvs};
        ge   = (rem2 >= {1'b0, dv_in.dvs});
        dv_next.rem = ge ? diff[35:0] : rem2[35:0];
        dv_next.num = {dv_in.num[62:0], 1'b0};
        dv_next.quo = {dv_in.quo[62:0], ge};
        dv_next.dvs = dv_in.dvs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg <= dv_next;
            sb_reg <= sb_in;
        end
    end

    assign vld_out = vld_reg;
    assign dv_out  = dv_reg;
    assign sb_out  = sb_reg;

endmodule

`default_nettype wire

### src/sprite_screen_projection_top.sv
// Sprite screen projection: one sprite per cycle. 173 register stages: 33 root cells,
// 18 bearing CORDIC cells, 37 + 47 + 32 divide cells and six single registers.
// The whole chain advances together; it halts only while a result waits.
// Reset clears all valids and loads register defaults (scale and min_distance
// 1.0, viewer at origin heading 0). Heading sin/cos settle once the heading CORDIC
// cells and the sin/cos registers have filled after reset.
`default_nettype none

module sprite_screen_projection_top
    import spp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    spp_in_if.sink   sprite_in,
    spp_out_if.source result_out,
    spp_cfg_if.sink  cfg
);

    // Configuration registers
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic [15:0]        angle_reg;
    logic [31:0]        scale_reg;
    logic [31:0]        min_dist_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg       <= '0;
            vy_reg       <= '0;
            angle_reg    <= '0;
            scale_reg    <= 32'd65536;
            min_dist_reg <= 32'd65536;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_VIEWER_X:     vx_reg       <= cfg.data;
                REG_VIEWER_Y:     vy_reg       <= cfg.data;
                REG_VIEWER_ANGLE: angle_reg    <= cfg.data[15:0];
                REG_SCALE:        scale_reg    <= cfg.data;
                REG_MIN_DISTANCE: min_dist_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    logic en;
    logic out_vld_reg;

    assign en              = !out_vld_reg || result_out.ready;
    assign sprite_in.ready = en;

    // Heading sin/cos: free-running rotation CORDIC on the current heading
    logic               ang_vld [0:CORDIC_STEPS];
    cd_t                ang_dat [0:CORDIC_STEPS];
    sb_t                ang_sb  [0:CORDIC_STEPS];
    logic signed [25:0] za;
    logic               flip;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    sb_t                ang_sb0;

    always_comb
    begin
        za   = signed'({2'b00, angle_reg, 8'h00});
        flip = 1'b0;
        if (za >= HALF_TURN)
            za = za - FULL_TURN;
        if (za > QUARTER_TURN)
        begin
            za   = za - HALF_TURN;
            flip = 1'b1;
        end
        else if (za < -QUARTER_TURN)
        begin
            za   = za + HALF_TURN;
            flip = 1'b1;
        end
        ang_sb0           = '0;
        ang_sb0.projected = flip;   // flip rides along with its angle
    end

    assign ang_vld[0]   = 1'b1;
    assign ang_dat[0].x = CORDIC_GAIN;
    assign ang_dat[0].y = '0;
    assign ang_dat[0].z = za;
    assign ang_sb[0]    = ang_sb0;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_ang
        spp_cordic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (1'b1),
            .mode    (1'b0),
            .step    (5'(i)),
            .vld_in  (ang_vld[i]),
            .cd_in   (ang_dat[i]),
            .sb_in   (ang_sb[i]),
            .vld_out (ang_vld[i+1]),
            .cd_out  (ang_dat[i+1]),
            .sb_out  (ang_sb[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ang_vld[CORDIC_STEPS])
        begin
            cos_reg <= 32'(ang_sb[CORDIC_STEPS].projected ? -ang_dat[CORDIC_STEPS].x
                                                          : ang_dat[CORDIC_STEPS].x);
            sin_reg <= 32'(ang_sb[CORDIC_STEPS].projected ? -ang_dat[CORDIC_STEPS].y
                                                          : ang_dat[CORDIC_STEPS].y);
        end
    end

    // Stage A: offsets
    logic               a_vld_reg;
    logic signed [32:0] a_dx_reg;
    logic signed [32:0] a_dy_reg;

    // Stage B: squares
    logic               b_vld_reg;
    logic [63:0]        b_sqx_reg;
    logic [63:0]        b_sqy_reg;
    logic signed [32:0] b_dx_reg;
    logic signed [32:0] b_dy_reg;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic signed [32:0] ax_w;
    logic signed [32:0] ay_w;

    always_comb
    begin
        ax_w = a_dx_reg[32] ? -a_dx_reg : a_dx_reg;
        ay_w = a_dy_reg[32] ? -a_dy_reg : a_dy_reg;
        ax   = ax_w[31:0];
        ay   = ay_w[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= sprite_in.valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx_reg  <= 33'(sprite_in.sprite_x) - 33'(vx_reg);
            a_dy_reg  <= 33'(sprite_in.sprite_y) - 33'(vy_reg);
            b_sqx_reg <= ax * ax;
            b_sqy_reg <= ay * ay;
            b_dx_reg  <= a_dx_reg;
            b_dy_reg  <= a_dy_reg;
        end
    end

    // Distance: square root chain
    logic sq_vld [0:SQRT_STEPS];
    sq_t  sq_dat [0:SQRT_STEPS];
    sb_t  sq_sb  [0:SQRT_STEPS];
    sb_t  sq_sb0;

    always_comb
    begin
        sq_sb0    = '0;
        sq_sb0.dx = b_dx_reg;
        sq_sb0.dy = b_dy_reg;
    end

    assign sq_vld[0]      = b_vld_reg;
    assign sq_dat[0].rad  = 66'(b_sqx_reg) + 66'(b_sqy_reg);
    assign sq_dat[0].rem  = '0;
    assign sq_dat[0].root = '0;
    assign sq_sb[0]       = sq_sb0;

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sq
        spp_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (sq_vld[i]),
            .sq_in   (sq_dat[i]),
            .sb_in   (sq_sb[i]),
            .vld_out (sq_vld[i+1]),
            .sq_out  (sq_dat[i+1]),
            .sb_out  (sq_sb[i+1])
        );
    end

    // R1: rotation products, R2: rotated offset
    logic               r1_vld_reg;
    logic signed [64:0] r1_pxc_reg;
    logic signed [64:0] r1_pys_reg;
    logic signed [64:0] r1_pxs_reg;
    logic signed [64:0] r1_pyc_reg;
    sb_t                r1_sb_reg;
    sb_t                r1_sb;
    logic               r2_vld_reg;
    logic signed [35:0] r2_ry_reg;
    sb_t                r2_sb_reg;
    sb_t                r2_sb;
    logic signed [65:0] dr_x;
    logic signed [65:0] dr_y;

    always_comb
    begin
        r1_sb           = sq_sb[SQRT_STEPS];
        r1_sb.distance  = sq_dat[SQRT_STEPS].root;
        r1_sb.projected = sq_dat[SQRT_STEPS].root > {1'b0, min_dist_reg};
        dr_x = 66'(r1_pxc_reg) - 66'(r1_pys_reg);
        dr_y = 66'(r1_pxs_reg) + 66'(r1_pyc_reg);
        r2_sb    = r1_sb_reg;
        r2_sb.rx = 36'(dr_x >>> 30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_vld_reg <= sq_vld[SQRT_STEPS];
            r2_vld_reg <= r1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_pxc_reg <= r1_sb.dx * cos_reg;
            r1_pys_reg <= r1_sb.dy * sin_reg;
            r1_pxs_reg <= r1_sb.dx * sin_reg;
            r1_pyc_reg <= r1_sb.dy * cos_reg;
            r1_sb_reg  <= r1_sb;
            r2_sb_reg  <= r2_sb;
            r2_ry_reg  <= 36'(dr_y >>> 30);
        end
    end

    // Bearing: vectoring CORDIC chain with half-plane fold
    logic               vc_vld [0:CORDIC_STEPS];
    cd_t                vc_dat [0:CORDIC_STEPS];
    sb_t                vc_sb  [0:CORDIC_STEPS];
    cd_t                vc_dat0;
    logic signed [37:0] rx_e;
    logic signed [37:0] ry_e;

    always_comb
    begin
        rx_e = 38'(r2_sb_reg.rx);
        ry_e = 38'(r2_ry_reg);
        if (r2_sb_reg.rx < 36'sd0)
        begin
            vc_dat0.x = -rx_e;
            vc_dat0.y = -ry_e;
            vc_dat0.z = (r2_ry_reg < 36'sd0) ? -HALF_TURN : HALF_TURN;
        end
        else
        begin
            vc_dat0.x = rx_e;
            vc_dat0.y = ry_e;
            vc_dat0.z = '0;
        end
    end

    assign vc_vld[0] = r2_vld_reg;
    assign vc_dat[0] = vc_dat0;
    assign vc_sb[0]  = r2_sb_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vc
        spp_cordic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .mode    (1'b1),
            .step    (5'(i)),
            .vld_in  (vc_vld[i]),
            .cd_in   (vc_dat[i]),
            .sb_in   (vc_sb[i]),
            .vld_out (vc_vld[i+1]),
            .cd_out  (vc_dat[i+1]),
            .sb_out  (vc_sb[i+1])
        );
    end

    // N: offset column dividend
    logic               n_vld_reg;
    logic signed [55:0] n_val_reg;
    sb_t                n_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_vld_reg <= 1'b0;
        else if (en)
            n_vld_reg <= vc_vld[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_val_reg <= 56'(vc_dat[CORDIC_STEPS].z) * CTR_MUL + CTR_ADD;
            n_sb_reg  <= vc_sb[CORDIC_STEPS];
        end
    end

    // Center column divide
    logic ct_vld [0:CTR_STEPS];
    dv_t  ct_dat [0:CTR_STEPS];
    sb_t  ct_sb  [0:CTR_STEPS];

    assign ct_vld[0]     = n_vld_reg;
    assign ct_dat[0].rem = 36'(n_val_reg[55:CTR_STEPS]);
    assign ct_dat[0].num = {n_val_reg[CTR_STEPS-1:0], {(64-CTR_STEPS){1'b0}}};
    assign ct_dat[0].quo = '0;
    assign ct_dat[0].dvs = 36'(CTR_DIV);
    assign ct_sb[0]      = n_sb_reg;

    for (genvar i = 0; i < CTR_STEPS; i++)
    begin : g_ct
        spp_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (ct_vld[i]),
            .dv_in   (ct_dat[i]),
            .sb_in   (ct_sb[i]),
            .vld_out (ct_vld[i+1]),
            .dv_out  (ct_dat[i+1]),
            .sb_out  (ct_sb[i+1])
        );
    end

    // Half size divide: scale*2^15 / distance
    logic hf_vld [0:HALF_STEPS];
    dv_t  hf_dat [0:HALF_STEPS];
    sb_t  hf_sb  [0:HALF_STEPS];
    sb_t  hf_sb0;

    always_comb
    begin
        hf_sb0        = ct_sb[CTR_STEPS];
        hf_sb0.center = $signed({1'b0, ct_dat[CTR_STEPS].quo[CTR_STEPS-1:0]}) - CTR_OFS_Q;
    end

    assign hf_vld[0]     = ct_vld[CTR_STEPS];
    assign hf_dat[0].rem = '0;
    assign hf_dat[0].num = {scale_reg, 32'h0};
    assign hf_dat[0].quo = '0;
    assign hf_dat[0].dvs = 36'(ct_sb[CTR_STEPS].distance);
    assign hf_sb[0]      = hf_sb0;

    for (genvar i = 0; i < HALF_STEPS; i++)
    begin : g_hf
        spp_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (hf_vld[i]),
            .dv_in   (hf_dat[i]),
            .sb_in   (hf_sb[i]),
            .vld_out (hf_vld[i+1]),
            .dv_out  (hf_dat[i+1]),
            .sb_out  (hf_sb[i+1])
        );
    end

    // Size divide: scale / |rx|; a zero divisor yields all ones
    logic        sz_vld [0:SIZE_STEPS];
    dv_t         sz_dat [0:SIZE_STEPS];
    sb_t         sz_sb  [0:SIZE_STEPS];
    sb_t         sz_sb0;
    logic [35:0] hf_depth;

    always_comb
    begin
        sz_sb0      = hf_sb[HALF_STEPS];
        sz_sb0.half = hf_dat[HALF_STEPS].quo[46:0];
        hf_depth    = hf_sb[HALF_STEPS].rx[35] ? 36'(-hf_sb[HALF_STEPS].rx)
                                               : 36'(hf_sb[HALF_STEPS].rx);
    end

    assign sz_vld[0]     = hf_vld[HALF_STEPS];
    assign sz_dat[0].rem = '0;
    assign sz_dat[0].num = {scale_reg, 32'h0};
    assign sz_dat[0].quo = '0;
    assign sz_dat[0].dvs = hf_depth;
    assign sz_sb[0]      = sz_sb0;

    for (genvar i = 0; i < SIZE_STEPS; i++)
    begin : g_sz
        spp_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (sz_vld[i]),
            .dv_in   (sz_dat[i]),
            .sb_in   (sz_sb[i]),
            .vld_out (sz_vld[i+1]),
            .dv_out  (sz_dat[i+1]),
            .sb_out  (sz_sb[i+1])
        );
    end

    // Output register
    function automatic logic signed [15:0] col_of(input logic signed [48:0] q);
        logic signed [48:0] m;
        logic signed [48:0] v;
        logic signed [15:0] r;
        m = q[48] ? -q : q;
        v = m >>> 16;
        if (q[48])
            v = -v;
        if (v > 49'sd32767)
            r = 16'sh7fff;
        else if (v < -49'sd32768)
            r = -16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    logic signed [15:0] col_b_reg;
    logic signed [15:0] col_e_reg;
    logic [31:0]        depth_reg;
    logic [15:0]        size_reg;
    logic               proj_reg;
    sb_t                fin_sb;
    logic [31:0]        fin_q;
    logic [35:0]        fin_depth;
    logic signed [48:0] ctr_e;
    logic signed [48:0] half_e;

    always_comb
    begin
        fin_sb    = sz_sb[SIZE_STEPS];
        fin_q     = sz_dat[SIZE_STEPS].quo[31:0];
        fin_depth = fin_sb.rx[35] ? 36'(-fin_sb.rx) : 36'(fin_sb.rx);
        ctr_e     = 49'(fin_sb.center);
        half_e    = signed'({2'b00, fin_sb.half});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= sz_vld[SIZE_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            proj_reg <= fin_sb.projected;
            if (fin_sb.projected)
            begin
                col_b_reg <= col_of(ctr_e - half_e);
                col_e_reg <= col_of(ctr_e + half_e);
                depth_reg <= (|fin_depth[35:32]) ? 32'hFFFF_FFFF : fin_depth[31:0];
                size_reg  <= (|fin_q[31:16]) ? 16'hFFFF : fin_q[15:0];
            end
            else
            begin
                col_b_reg <= -16'sd1;
                col_e_reg <= -16'sd1;
                depth_reg <= fin_sb.distance[31:0];
                size_reg  <= '0;
            end
        end
    end

    assign result_out.valid       = out_vld_reg;
    assign result_out.col_begin   = col_b_reg;
    assign result_out.col_end     = col_e_reg;
    assign result_out.depth       = depth_reg;
    assign result_out.sprite_size = size_reg;
    assign result_out.projected   = proj_reg;

endmodule

`default_nettype wire

### src/spp_checker.sv
// spp_checker: port-level assertions for the sprite projection top, and the
// bind that attaches them. Depends on spp_pkg and the top level.
`default_nettype none

module spp_checker
    import spp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] col_begin,
    input logic signed [15:0] col_end,
    input logic [31:0]        depth,
    input logic [15:0]        sprite_size,
    input logic               projected
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(col_begin) && $stable(col_end)
            && $stable(depth) && $stable(sprite_size) && $stable(projected))
        else $error("result changed while stalled");

    // Unprojected sprites carry the fixed column and size markers
    a_unproj: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !projected |-> col_begin == -16'sd1 && col_end == -16'sd1
            && sprite_size == 16'd0)
        else $error("unprojected result has bad columns or size");

    // Column span is never inverted
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && projected |-> col_begin <= col_end)
        else $error("col_begin above col_end");

    // With no result pending the input side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind sprite_screen_projection_top spp_checker u_spp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (sprite_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .col_begin   (result_out.col_begin),
    .col_end     (result_out.col_end),
    .depth       (result_out.depth),
    .sprite_size (result_out.sprite_size),
    .projected   (result_out.projected)
);

`default_nettype wire
